/* hdl/ipv4fd_pkg.sv */
// ----------------------------------------------------------------------------
// ipv4fd_pkg - shared types and constants of the IPv4 forwarding decision
// Action and drop codes, route register defaults, the work entry passed
// from the classify front end to the counter back end.
// ----------------------------------------------------------------------------
package ipv4fd_pkg;

  // Default sizes
  localparam int PORT_COUNT_DEF  = 2;
  localparam int ROUTE_COUNT_DEF = 2;
  localparam int ROUTE_SLOTS     = 2;
  localparam int RIDX_W          = 1;
  localparam int QUEUE_DEPTH     = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Register offsets inside one route group of four
  localparam logic [1:0] CFG_NET    = 2'd0;
  localparam logic [1:0] CFG_LEN    = 2'd1;
  localparam logic [1:0] CFG_EGRESS = 2'd2;
  localparam logic [1:0] CFG_MAC    = 2'd3;

  // Request kinds
  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // Ethertypes
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_MPLS = 16'h8847;

  typedef logic [1:0] action_t;
  localparam action_t ACT_FORWARD = 2'd0;
  localparam action_t ACT_DROP    = 2'd1;
  localparam action_t ACT_MPLS    = 2'd2;
  localparam action_t ACT_REPLY   = 2'd3;

  typedef logic [2:0] cause_t;
  localparam cause_t WHY_NONE     = 3'd0;
  localparam cause_t WHY_ACL      = 3'd1;
  localparam cause_t WHY_NOT_IPV4 = 3'd2;
  localparam cause_t WHY_NO_ROUTE = 3'd3;
  localparam cause_t WHY_TTL      = 3'd4;

  // Route register reset values
  localparam logic [31:0] ROUTE_NET_RST [ROUTE_SLOTS] = '{32'h0A00_0100, 32'h0A00_0200};
  localparam logic [5:0]  ROUTE_LEN_RST [ROUTE_SLOTS] = '{6'd24, 6'd24};
  localparam logic        ROUTE_EG_RST  [ROUTE_SLOTS] = '{1'b0, 1'b1};
  localparam logic [47:0] ROUTE_MAC_RST [ROUTE_SLOTS] = '{48'h0200_0000_0001,
                                                          48'h0200_0000_0002};

  // Classified request, front end to back end
  typedef struct packed {
    logic        is_read;    // counter read request
    logic        port;       // ingress / read port, saturated
    logic        egress;     // route port as reported
    logic        egress_idx; // route port, saturated, for tx counting
    action_t     action;
    cause_t      cause;
    logic [47:0] mac;
    logic [7:0]  ttl;
    logic [15:0] bytes;
  } work_t;

  // Network mask for a prefix length; lengths above 32 act as 32
  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'd0;
    end else if (len >= 6'd32) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = ~(32'hFFFF_FFFF >> len);
    end
    return m;
  endfunction

endpackage

/* hdl/ipv4fd_front.sv */
// ----------------------------------------------------------------------------
// ipv4fd_front - request intake and classification
// Holds the route table, matches the destination against it and turns each
// accepted request into a work entry for the queue.
// ----------------------------------------------------------------------------
module ipv4fd_front #(
  parameter int PORT_COUNT  = ipv4fd_pkg::PORT_COUNT_DEF,
  parameter int ROUTE_COUNT = ipv4fd_pkg::ROUTE_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ipv4fd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipv4fd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_req_type,
  input  logic                             in_port_sel,
  input  logic                             in_acl_permit,
  input  logic [15:0]                      in_frame_type,
  input  logic [31:0]                      in_dest_addr,
  input  logic [7:0]                       in_hop_limit,
  input  logic [15:0]                      in_frame_bytes,
  input  logic                             q_full,
  output logic                             push,
  output ipv4fd_pkg::work_t                entry
);

  localparam int RS = ipv4fd_pkg::ROUTE_SLOTS;
  localparam int RW = ipv4fd_pkg::RIDX_W;

  // Route table
  logic [31:0] net_r [RS];
  logic [5:0]  len_r [RS];
  logic        eg_r  [RS];
  logic [47:0] mac_r [RS];

  logic [RW-1:0] cfg_slot;
  logic [1:0]    cfg_sub;

  assign cfg_slot = cfg_index[ipv4fd_pkg::CFG_IDX_W-1 -: RW];
  assign cfg_sub  = cfg_index[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RS; i++) begin
        net_r[i] <= ipv4fd_pkg::ROUTE_NET_RST[i];
        len_r[i] <= ipv4fd_pkg::ROUTE_LEN_RST[i];
        eg_r[i]  <= ipv4fd_pkg::ROUTE_EG_RST[i];
        mac_r[i] <= ipv4fd_pkg::ROUTE_MAC_RST[i];
      end
    end else if (cfg_we) begin
      case (cfg_sub)
        ipv4fd_pkg::CFG_NET:    net_r[cfg_slot] <= cfg_data[31:0];
        ipv4fd_pkg::CFG_LEN:    len_r[cfg_slot] <= cfg_data[5:0];
        ipv4fd_pkg::CFG_EGRESS: eg_r[cfg_slot]  <= cfg_data[0];
        ipv4fd_pkg::CFG_MAC:    mac_r[cfg_slot] <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // First matching route; walk backward so the lowest index wins
  logic          hit;
  logic [RW-1:0] hit_r;
  logic [31:0]   mask;

  always_comb begin
    hit   = 1'b0;
    hit_r = '0;
    mask  = '0;
    for (int r = ROUTE_COUNT - 1; r >= 0; r--) begin
      mask = ipv4fd_pkg::prefix_mask(len_r[r]);
      if ((in_dest_addr & mask) == (net_r[r] & mask)) begin
        hit   = 1'b1;
        hit_r = RW'(r);
      end
    end
  end

  // Port saturation to the configured port count
  logic port_sat;
  logic eg_sat;

  assign port_sat = (32'(in_port_sel) >= 32'(PORT_COUNT)) ? 1'(PORT_COUNT - 1) : in_port_sel;
  assign eg_sat   = (32'(eg_r[hit_r]) >= 32'(PORT_COUNT)) ? 1'(PORT_COUNT - 1)
                                                          : eg_r[hit_r];

  // Classification
  always_comb begin
    entry            = '0;
    entry.is_read    = (in_req_type == ipv4fd_pkg::REQ_READ);
    entry.port       = port_sat;
    entry.bytes      = in_frame_bytes;
    entry.egress_idx = eg_sat;
    entry.action     = ipv4fd_pkg::ACT_REPLY;
    entry.cause      = ipv4fd_pkg::WHY_NONE;
    if (in_req_type == ipv4fd_pkg::REQ_PACKET) begin
      if (!in_acl_permit) begin
        entry.action = ipv4fd_pkg::ACT_DROP;
        entry.cause  = ipv4fd_pkg::WHY_ACL;
      end else if (in_frame_type == ipv4fd_pkg::ETYPE_MPLS) begin
        entry.action = ipv4fd_pkg::ACT_MPLS;
      end else if (in_frame_type != ipv4fd_pkg::ETYPE_IPV4) begin
        entry.action = ipv4fd_pkg::ACT_DROP;
        entry.cause  = ipv4fd_pkg::WHY_NOT_IPV4;
      end else if (!hit) begin
        entry.action = ipv4fd_pkg::ACT_DROP;
        entry.cause  = ipv4fd_pkg::WHY_NO_ROUTE;
      end else if (in_hop_limit <= 8'd1) begin
        entry.action = ipv4fd_pkg::ACT_DROP;
        entry.cause  = ipv4fd_pkg::WHY_TTL;
      end else begin
        entry.action = ipv4fd_pkg::ACT_FORWARD;
        entry.egress = eg_r[hit_r];
        entry.mac    = mac_r[hit_r];
        entry.ttl    = in_hop_limit - 8'd1;
      end
    end
  end

  // Handshake
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

endmodule

/* hdl/ipv4fd_queue.sv */
// ----------------------------------------------------------------------------
// ipv4fd_queue - short work queue
// Register-based FIFO between classification and counting, so either side
// can stall without blocking the other until the queue is full or empty.
// ----------------------------------------------------------------------------
module ipv4fd_queue #(
  parameter int DEPTH = ipv4fd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ipv4fd_pkg::work_t wr_entry,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output ipv4fd_pkg::work_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ipv4fd_pkg::work_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  // Occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

/* hdl/ipv4fd_back.sv */
// ----------------------------------------------------------------------------
// ipv4fd_back - counter update and result register
// Takes work entries in order, updates the per-port counters and registers
// the result together with the counters of the named port.
// ----------------------------------------------------------------------------
module ipv4fd_back #(
  parameter int PORT_COUNT = ipv4fd_pkg::PORT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  ipv4fd_pkg::work_t   head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output ipv4fd_pkg::action_t out_action,
  output ipv4fd_pkg::cause_t  out_drop_cause,
  output logic                out_egress_port,
  output logic [47:0]         out_nh_mac,
  output logic [7:0]          out_ttl_out,
  output logic [63:0]         out_rx_count,
  output logic [63:0]         out_rx_byte_count,
  output logic [63:0]         out_tx_count,
  output logic [63:0]         out_drop_count
);

  localparam int PIDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

  // Per-port counters
  logic [PORT_COUNT-1:0][63:0] rx_pkt_r,  rx_pkt_nxt;
  logic [PORT_COUNT-1:0][63:0] rx_byte_r, rx_byte_nxt;
  logic [PORT_COUNT-1:0][63:0] tx_pkt_r,  tx_pkt_nxt;
  logic [PORT_COUNT-1:0][63:0] drop_r,    drop_nxt;

  logic              out_valid_r;
  ipv4fd_pkg::work_t res_r;
  logic [63:0]       rx_cnt_r, rx_byte_cnt_r, tx_cnt_r, drop_cnt_r;

  logic [PIDX_W-1:0] p, e;

  assign p   = PIDX_W'(head.port);
  assign e   = PIDX_W'(head.egress_idx);
  assign pop = q_not_empty && (!out_valid_r || out_ready);

  // Counter next values
  always_comb begin
    rx_pkt_nxt  = rx_pkt_r;
    rx_byte_nxt = rx_byte_r;
    tx_pkt_nxt  = tx_pkt_r;
    drop_nxt    = drop_r;
    if (pop && !head.is_read) begin
      rx_pkt_nxt[p]  = rx_pkt_r[p] + 64'd1;
      rx_byte_nxt[p] = rx_byte_r[p] + 64'(head.bytes);
      if (head.action == ipv4fd_pkg::ACT_DROP) begin
        drop_nxt[p] = drop_r[p] + 64'd1;
      end
      if (head.action == ipv4fd_pkg::ACT_FORWARD) begin
        tx_pkt_nxt[e] = tx_pkt_r[e] + 64'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_pkt_r  <= '0;
      rx_byte_r <= '0;
      tx_pkt_r  <= '0;
      drop_r    <= '0;
    end else begin
      rx_pkt_r  <= rx_pkt_nxt;
      rx_byte_r <= rx_byte_nxt;
      tx_pkt_r  <= tx_pkt_nxt;
      drop_r    <= drop_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r         <= head;
      rx_cnt_r      <= rx_pkt_nxt[p];
      rx_byte_cnt_r <= rx_byte_nxt[p];
      tx_cnt_r      <= tx_pkt_nxt[p];
      drop_cnt_r    <= drop_nxt[p];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = res_r.action;
  assign out_drop_cause    = res_r.cause;
  assign out_egress_port   = res_r.egress;
  assign out_nh_mac        = res_r.mac;
  assign out_ttl_out       = res_r.ttl;
  assign out_rx_count      = rx_cnt_r;
  assign out_rx_byte_count = rx_byte_cnt_r;
  assign out_tx_count      = tx_cnt_r;
  assign out_drop_count    = drop_cnt_r;

  // Checks
  a_read_keeps_counters: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.is_read) |=> ($stable(rx_pkt_r) && $stable(rx_byte_r)
                               && $stable(tx_pkt_r) && $stable(drop_r)))
    else $error("counter read changed a counter");

  a_forward_ttl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action == ipv4fd_pkg::ACT_FORWARD) |-> (out_ttl_out != 8'd0))
    else $error("forwarded packet with zero ttl");

  a_drop_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action == ipv4fd_pkg::ACT_DROP)
      |-> (out_drop_cause != ipv4fd_pkg::WHY_NONE))
    else $error("drop without cause");

endmodule

/* hdl/ipv4_forwarding_decision_top.sv */
// ----------------------------------------------------------------------------
// ipv4_forwarding_decision_top - IPv4 forwarding decision
// Routes parsed packet headers by prefix, checks ACL verdict and TTL, keeps
// per-port 64-bit packet, byte, transmit and drop counters.
//
//   channel  | handshake            | contents
//   ---------+----------------------+--------------------------------------
//   in_      | in_valid / in_ready  | header or counter-read request
//   out_     | out_valid / out_ready| action, cause, route data, counters
//   cfg_     | cfg_we               | route table write, index + data
//
// One request per cycle sustained while out_ready holds high; a request is
// classified into the queue when accepted, then the counter update loads the
// result reg from the queue head, and out_valid rises with that load.
// Counter updates are 64-bit adds in the back end.
// A two-entry queue decouples intake from a stalled result port.
// Reset (synchronous, rst_n low) clears counters and loads default routes.
// ----------------------------------------------------------------------------
module ipv4_forwarding_decision_top #(
  parameter int PORT_COUNT  = ipv4fd_pkg::PORT_COUNT_DEF,
  parameter int ROUTE_COUNT = ipv4fd_pkg::ROUTE_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ipv4fd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipv4fd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_req_type,
  input  logic                             in_port_sel,
  input  logic                             in_acl_permit,
  input  logic [15:0]                      in_frame_type,
  input  logic [31:0]                      in_dest_addr,
  input  logic [7:0]                       in_hop_limit,
  input  logic [15:0]                      in_frame_bytes,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_action,
  output logic [2:0]                       out_drop_cause,
  output logic                             out_egress_port,
  output logic [47:0]                      out_nh_mac,
  output logic [7:0]                       out_ttl_out,
  output logic [63:0]                      out_rx_count,
  output logic [63:0]                      out_rx_byte_count,
  output logic [63:0]                      out_tx_count,
  output logic [63:0]                      out_drop_count
);

  ipv4fd_pkg::work_t wr_entry, head;
  logic              push, pop, q_full, q_not_empty;

  // Intake and classification
  ipv4fd_front #(
    .PORT_COUNT  (PORT_COUNT),
    .ROUTE_COUNT (ROUTE_COUNT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_port_sel    (in_port_sel),
    .in_acl_permit  (in_acl_permit),
    .in_frame_type  (in_frame_type),
    .in_dest_addr   (in_dest_addr),
    .in_hop_limit   (in_hop_limit),
    .in_frame_bytes (in_frame_bytes),
    .q_full         (q_full),
    .push           (push),
    .entry          (wr_entry)
  );

  // Work queue
  ipv4fd_queue #(
    .DEPTH (ipv4fd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_entry  (wr_entry),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  // Counters and result
  ipv4fd_back #(
    .PORT_COUNT (PORT_COUNT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_action        (out_action),
    .out_drop_cause    (out_drop_cause),
    .out_egress_port   (out_egress_port),
    .out_nh_mac        (out_nh_mac),
    .out_ttl_out       (out_ttl_out),
    .out_rx_count      (out_rx_count),
    .out_rx_byte_count (out_rx_byte_count),
    .out_tx_count      (out_tx_count),
    .out_drop_count    (out_drop_count)
  );

endmodule
